[sv/lfsa_pkg.sv]
// ----------------------------------------------------------------------------
// lfsa_pkg
// shared types and constants of the lowest free slot allocator
// ----------------------------------------------------------------------------
package lfsa_pkg;

    localparam int SLOTS    = 64;
    localparam int CLIENTS  = 256;
    localparam int SLOT_W   = 6;
    localparam int ID_W     = 8;
    localparam int USES_W   = 16;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int HOLD_W   = $clog2(CLIENTS);

    localparam logic [USES_W-1:0] USE_MAX = {USES_W{1'b1}};

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_DEPART = 1'b1;

    typedef struct packed {
        logic            operation;
        logic [ID_W-1:0] client_id;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [USES_W-1:0] slot_uses;
        logic              full_res;
    } t_out_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] slot;
    } t_pick;

endpackage

[sv/lfsa_pick.sv]
// ----------------------------------------------------------------------------
// lfsa_pick
// lowest free slot among the enabled slots
// ----------------------------------------------------------------------------
module lfsa_pick (
    input  logic [lfsa_pkg::SLOTS-1:0] i_free,
    input  logic [lfsa_pkg::CNT_W-1:0] i_slot_count,
    output lfsa_pkg::t_pick            o_pick
);

    logic [lfsa_pkg::CNT_W-1:0] w_count;
    logic [lfsa_pkg::SLOTS-1:0] w_enable;
    logic [lfsa_pkg::SLOTS-1:0] w_avail;
    logic [lfsa_pkg::SLOTS-1:0] w_lowest;
    logic [lfsa_pkg::IDX_W-1:0] w_index;

    assign w_count = (i_slot_count > lfsa_pkg::CNT_W'(lfsa_pkg::SLOTS))
                   ? lfsa_pkg::CNT_W'(lfsa_pkg::SLOTS) : i_slot_count;

    always_comb begin
        for (int i = 0; i < lfsa_pkg::SLOTS; i++) begin
            w_enable[i] = (lfsa_pkg::CNT_W'(i) < w_count);
        end
    end

    assign w_avail  = i_free & w_enable;
    // isolate lowest set bit
    assign w_lowest = w_avail & (~w_avail + lfsa_pkg::SLOTS'(1));

    always_comb begin
        w_index = '0;
        for (int i = 0; i < lfsa_pkg::SLOTS; i++) begin
            if (w_lowest[i]) begin
                w_index = w_index | lfsa_pkg::IDX_W'(i);
            end
        end
    end

    assign o_pick.found = |w_avail;
    assign o_pick.slot  = w_index;

endmodule

[sv/lowest_free_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_unit
// grants the lowest free enabled slot on arrival, frees the held slot on
// departure, and reports the slot with its use count
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | i_in_valid o_in_stall i_in_item  | item into the block
//  out     | o_out_valid i_out_stall o_out_item | result item out
//  cfg     | i_cfg_we i_cfg_data              | slot_count write
//
//  arrival: IDLE then USE; departure: IDLE, HOLD, USE; result registered on leaving USE;
//  the next item is taken the cycle after the result is registered
//  HOLD waits for the holder memory read; USE uses the use-count memory read
//  reset marks all slots free, sets slot_count to 64, clears use-count valid bits; no clearing pass
//  a stalled result holds the last step until the output register is free
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lfsa_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lfsa_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_we,
    input  logic [lfsa_pkg::CNT_W-1:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HOLD = 2'd1;
    localparam logic [1:0] S_USE  = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [lfsa_pkg::SLOTS-1:0]  r_free, n_free;
    logic [lfsa_pkg::CNT_W-1:0]  r_cnt;
    logic [lfsa_pkg::SLOTS-1:0]  r_use_vld;
    logic                        r_op;
    logic                        r_full;
    logic [lfsa_pkg::IDX_W-1:0]  r_slot, n_slot;
    logic                        r_out_valid;
    lfsa_pkg::t_out_item         r_out;

    logic [lfsa_pkg::IDX_W-1:0]  r_hold_rdata;
    logic [lfsa_pkg::USES_W-1:0] r_use_rdata;
    logic [lfsa_pkg::IDX_W-1:0]  hold_mem [lfsa_pkg::CLIENTS];
    logic [lfsa_pkg::USES_W-1:0] use_mem  [lfsa_pkg::SLOTS];

    lfsa_pkg::t_pick             w_pick;
    logic                        w_accept;
    logic                        w_arrive;
    logic                        w_out_free;
    logic                        w_finish;
    logic                        w_use_rd;
    logic [lfsa_pkg::IDX_W-1:0]  w_use_addr;
    logic                        w_use_wr;
    logic [lfsa_pkg::USES_W-1:0] w_count;
    logic [lfsa_pkg::USES_W-1:0] w_count_inc;
    logic [lfsa_pkg::HOLD_W-1:0] w_id;

    lfsa_pick u_pick (
        .i_free       (r_free),
        .i_slot_count (r_cnt),
        .o_pick       (w_pick)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_arrive    = (i_in_item.operation == lfsa_pkg::OP_ARRIVE);
    assign w_id        = lfsa_pkg::HOLD_W'(i_in_item.client_id);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_finish    = (r_state == S_USE) && w_out_free;

    assign w_count     = r_use_vld[r_slot] ? r_use_rdata : '0;
    assign w_count_inc = (w_count == lfsa_pkg::USE_MAX) ? w_count
                       : w_count + lfsa_pkg::USES_W'(1);
    assign w_use_wr    = w_finish && (r_op == lfsa_pkg::OP_ARRIVE) && !r_full;

    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_slot     = r_slot;
        w_use_rd   = 1'b0;
        w_use_addr = w_pick.slot;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_arrive) begin
                        n_slot     = w_pick.slot;
                        w_use_rd   = 1'b1;
                        w_use_addr = w_pick.slot;
                        if (w_pick.found) begin
                            n_free[w_pick.slot] = 1'b0;
                        end
                        n_state = S_USE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                n_slot              = r_hold_rdata;
                n_free[r_hold_rdata] = 1'b1;
                w_use_rd            = 1'b1;
                w_use_addr          = r_hold_rdata;
                n_state             = S_USE;
            end
            S_USE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= {lfsa_pkg::SLOTS{1'b1}};
            r_cnt       <= lfsa_pkg::CNT_W'(64);
            r_use_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            if (i_cfg_we) begin
                r_cnt <= i_cfg_data;
            end
            if (w_use_wr) begin
                r_use_vld[r_slot] <= 1'b1;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (w_accept) begin
            r_op   <= i_in_item.operation;
            r_full <= w_arrive && !w_pick.found;
        end
        if (w_finish) begin
            if ((r_op == lfsa_pkg::OP_ARRIVE) && r_full) begin
                r_out.slot      <= '0;
                r_out.slot_uses <= '0;
                r_out.full_res  <= 1'b1;
            end else begin
                r_out.slot      <= lfsa_pkg::SLOT_W'(r_slot);
                r_out.slot_uses <= (r_op == lfsa_pkg::OP_ARRIVE) ? w_count_inc : w_count;
                r_out.full_res  <= 1'b0;
            end
        end
    end

    // holder table
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hold_rdata <= hold_mem[w_id];
        end
        if (w_accept && w_arrive && w_pick.found) begin
            hold_mem[w_id] <= w_pick.slot;
        end
    end

    // use counters
    always_ff @(posedge i_clk) begin
        if (w_use_rd) begin
            r_use_rdata <= use_mem[w_use_addr];
        end
        if (w_use_wr) begin
            use_mem[r_slot] <= w_count_inc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_grant_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_arrive && w_pick.found) |=> !r_free[$past(w_pick.slot)])
        else $error("granted slot still marked free");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.full_res) |->
        (o_out_item.slot == '0 && o_out_item.slot_uses == '0))
        else $error("full result carries nonzero fields");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished step did not register a result");

    a_depart_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |=> r_free[$past(r_hold_rdata)])
        else $error("departure did not free its slot");
`endif

endmodule

[dv/tb_lowest_free_slot_allocator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lowest_free_slot_allocator_unit
// drives arrival and departure items into the slot allocator and checks each
// result item against a cycle-free predictor of slot grants, releases and use
// counts; covers slot_count extremes, full, repeated departure, disabled held
// slots and repeated reuse of one slot, with random gaps and output stalls
// ----------------------------------------------------------------------------
module tb_lowest_free_slot_allocator_unit;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    lfsa_pkg::t_in_item             i_in_item = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    lfsa_pkg::t_out_item            o_out_item;
    logic                           i_cfg_we = 1'b0;
    logic [lfsa_pkg::CNT_W-1:0]     i_cfg_data = '0;

    // predictor state
    bit [lfsa_pkg::SLOTS-1:0]       free_slots = '1;
    bit [lfsa_pkg::SLOT_W-1:0]      holder_of [lfsa_pkg::CLIENTS];
    bit [lfsa_pkg::USES_W-1:0]      uses_of [lfsa_pkg::SLOTS];
    bit [lfsa_pkg::CNT_W-1:0]       enabled_count = lfsa_pkg::CNT_W'(lfsa_pkg::SLOTS);

    lfsa_pkg::t_out_item            expected_results [$];
    bit                             known_client [lfsa_pkg::CLIENTS];
    logic [lfsa_pkg::ID_W-1:0]      known_ids [$];
    bit                             calm = 1'b0;
    int unsigned                    mismatch_count = 0;

    lowest_free_slot_allocator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(50_000_000);
        $display("tb_lowest_free_slot_allocator_unit: done, errors");
        $finish;
    end

    function automatic lfsa_pkg::t_out_item grant_or_free(input lfsa_pkg::t_in_item item);
        lfsa_pkg::t_out_item         res;
        bit [lfsa_pkg::SLOTS-1:0]    open_slots;
        bit [lfsa_pkg::SLOT_W-1:0]   s;
        int                          n;
        res = '0;
        s = '0;
        if (item.operation == lfsa_pkg::OP_ARRIVE) begin
            n = (enabled_count > lfsa_pkg::SLOTS) ? lfsa_pkg::SLOTS : int'(enabled_count);
            for (int k = 0; k < lfsa_pkg::SLOTS; k++) begin
                open_slots[k] = free_slots[k] && (k < n);
            end
            if (open_slots == '0) begin
                res.full_res = 1'b1;
            end else begin
                for (int k = lfsa_pkg::SLOTS - 1; k >= 0; k--) begin
                    if (open_slots[k]) s = lfsa_pkg::SLOT_W'(k);
                end
                free_slots[s] = 1'b0;
                if (uses_of[s] != lfsa_pkg::USE_MAX) uses_of[s]++;
                holder_of[item.client_id] = s;
                res.slot = s;
                res.slot_uses = uses_of[s];
            end
        end else begin
            s = holder_of[item.client_id];
            free_slots[s] = 1'b1;
            res.slot = s;
            res.slot_uses = uses_of[s];
        end
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly clients that still hold their slot, sometimes any known client
    function automatic logic [lfsa_pkg::ID_W-1:0] pick_departing_id();
        logic [lfsa_pkg::ID_W-1:0] id;
        int unsigned               tries;
        tries = ($urandom_range(9) == 0) ? 1 : 4;
        for (int k = 0; k < tries; k++) begin
            id = known_ids[$urandom_range(known_ids.size() - 1)];
            if (!free_slots[holder_of[id]]) return id;
        end
        return id;
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        mismatch_count++;
        $error("%s expected %0d got %0d", name, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        lfsa_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $error("result item with nothing expected, slot %0d", o_out_item.slot);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.slot !== want.slot)
                    report_field("slot", want.slot, o_out_item.slot);
                if (o_out_item.slot_uses !== want.slot_uses)
                    report_field("slot_uses", want.slot_uses, o_out_item.slot_uses);
                if (o_out_item.full_res !== want.full_res)
                    report_field("full_res", want.full_res, o_out_item.full_res);
            end
        end
    end

    initial begin : out_stall_driver
        int unsigned len;
        @(posedge i_clk);
        forever begin
            if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(99) < 60) begin
                i_out_stall <= 1'b0;
                len = $urandom_range(1, 8);
                repeat (len) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                repeat (len) @(posedge i_clk);
            end
        end
    end

    task automatic send_event(input logic op, input logic [lfsa_pkg::ID_W-1:0] id);
        lfsa_pkg::t_in_item    item;
        lfsa_pkg::t_out_item   res;
        int unsigned           gap;
        item.operation = op;
        item.client_id = id;
        i_in_item <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        res = grant_or_free(item);
        expected_results.push_back(res);
        if (op == lfsa_pkg::OP_ARRIVE && !res.full_res && !known_client[id]) begin
            known_client[id] = 1'b1;
            known_ids.push_back(id);
        end
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_slot_count(input logic [lfsa_pkg::CNT_W-1:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        enabled_count = value;
    endtask

    task automatic test_grant_and_release();
        send_event(lfsa_pkg::OP_ARRIVE, 8'h00);
        send_event(lfsa_pkg::OP_ARRIVE, 8'hFF);
        send_event(lfsa_pkg::OP_ARRIVE, 8'h55);
        send_event(lfsa_pkg::OP_ARRIVE, 8'hAA);
        send_event(lfsa_pkg::OP_DEPART, 8'hFF);
        send_event(lfsa_pkg::OP_ARRIVE, 8'h7F);
        // second departure frees a slot that another client now holds
        send_event(lfsa_pkg::OP_DEPART, 8'hFF);
        send_event(lfsa_pkg::OP_ARRIVE, 8'h80);
        send_event(lfsa_pkg::OP_DEPART, 8'h00);
    endtask

    task automatic test_slot_count_edges();
        set_slot_count(lfsa_pkg::CNT_W'(0));
        send_event(lfsa_pkg::OP_ARRIVE, 8'h01);
        set_slot_count(lfsa_pkg::CNT_W'(2));
        send_event(lfsa_pkg::OP_ARRIVE, 8'h02);
        send_event(lfsa_pkg::OP_ARRIVE, 8'h03);
        // held slot outside the enabled range is freed but not granted
        send_event(lfsa_pkg::OP_DEPART, 8'hAA);
        send_event(lfsa_pkg::OP_ARRIVE, 8'h04);
        send_event(lfsa_pkg::OP_DEPART, 8'h02);
        send_event(lfsa_pkg::OP_ARRIVE, 8'h04);
        set_slot_count(lfsa_pkg::CNT_W'(127));
        send_event(lfsa_pkg::OP_ARRIVE, 8'hFE);
        set_slot_count(lfsa_pkg::CNT_W'(65));
        send_event(lfsa_pkg::OP_ARRIVE, 8'hFD);
        set_slot_count(lfsa_pkg::CNT_W'(64));
        send_event(lfsa_pkg::OP_DEPART, 8'hFE);
        set_slot_count(lfsa_pkg::CNT_W'(1));
        send_event(lfsa_pkg::OP_ARRIVE, 8'h06);
    endtask

    task automatic run_traffic(input int unsigned n, input int unsigned arrive_pct);
        repeat (n) begin
            if (known_ids.size() == 0 || $urandom_range(99) < arrive_pct)
                send_event(lfsa_pkg::OP_ARRIVE, lfsa_pkg::ID_W'($urandom()));
            else
                send_event(lfsa_pkg::OP_DEPART, pick_departing_id());
        end
    endtask

    task automatic test_random_traffic();
        set_slot_count(lfsa_pkg::CNT_W'(64));
        calm = 1'b1;
        run_traffic(150, 65);
        calm = 1'b0;
        run_traffic(200, 55);
        set_slot_count(lfsa_pkg::CNT_W'(7));
        run_traffic(150, 50);
        set_slot_count(lfsa_pkg::CNT_W'(1));
        run_traffic(100, 50);
        set_slot_count(lfsa_pkg::CNT_W'(0));
        run_traffic(40, 50);
        set_slot_count(lfsa_pkg::CNT_W'(127));
        run_traffic(100, 60);
        set_slot_count(lfsa_pkg::CNT_W'(3));
        run_traffic(120, 40);
        set_slot_count(lfsa_pkg::CNT_W'($urandom_range(2, 126)));
        run_traffic(100, 50);
    endtask

    task automatic test_slot_reuse();
        int                        lowest;
        int                        pairs;
        logic [lfsa_pkg::ID_W-1:0] id;
        calm = 1'b1;
        set_slot_count(lfsa_pkg::CNT_W'(64));
        foreach (known_ids[k]) send_event(lfsa_pkg::OP_DEPART, known_ids[k]);
        lowest = -1;
        for (int s = lfsa_pkg::SLOTS - 1; s >= 0; s--) begin
            if (free_slots[s]) lowest = s;
        end
        if (lowest >= 0) begin
            // only the chosen slot can be granted
            set_slot_count(lfsa_pkg::CNT_W'(lowest + 1));
            id = lfsa_pkg::ID_W'($urandom());
            pairs = 20;
            repeat (pairs) begin
                send_event(lfsa_pkg::OP_ARRIVE, id);
                send_event(lfsa_pkg::OP_DEPART, id);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_grant_and_release();
        test_slot_count_edges();
        test_random_traffic();
        test_slot_reuse();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("tb_lowest_free_slot_allocator_unit: done, clean");
        end else begin
            $display("tb_lowest_free_slot_allocator_unit: done, errors");
        end
        $finish;
    end

endmodule
